>>> design/hgm_pkg.sv
package hgm_pkg;

  // grid geometry
  localparam int GRID_SIZE = 120;
  localparam int CELL_MM   = 25;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int HALF_MM   = (GRID_SIZE / 2) * CELL_MM;

  // field widths
  localparam int IDX_W     = 7;
  localparam int COORD_W   = 16;
  localparam int SPAN_W    = 11;
  localparam int ZMAX_W    = 12;
  localparam int CNT_W     = 20;
  localparam int SUM_W     = 36;
  localparam int CORNER_W  = 12;
  localparam int WORD_W    = CNT_W + SUM_W;
  localparam int CFG_IDX_W = 2;

  // binning: floor(v / CELL_MM) as a multiply by a rounded-up reciprocal
  localparam int BIN_IN_W  = 13;
  localparam int BIN_SHIFT = BIN_IN_W + $clog2(CELL_MM);
  localparam int RECIP_W   = BIN_IN_W + 1;
  localparam int PROD_W    = BIN_IN_W + RECIP_W;
  localparam int QBIN_W    = PROD_W - BIN_SHIFT;
  localparam logic [RECIP_W-1:0] BIN_RECIP =
    RECIP_W'(((1 << BIN_SHIFT) + CELL_MM - 1) / CELL_MM);

  // mean divider: quotient magnitude never exceeds 2^16
  localparam int QUO_W  = 17;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // op codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 2'd2;

  localparam logic [SPAN_W-1:0]         X_SPAN_RST   = 11'd1500;
  localparam logic [ZMAX_W-1:0]         Z_MAX_RST    = 12'd3000;
  localparam logic signed [COORD_W-1:0] OBSTACLE_RST = 16'sd200;

  typedef struct packed {
    logic latch_in;
    logic bin;
    logic rd;
    logic modify;
    logic dset;
    logic div_step;
    logic clr_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_last;
    logic       clr_last;
  } dp_sts_t;

endpackage

>>> design/hgm_ram.sv
module hgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hgm_datapath.sv
module hgm_datapath
  import hgm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [COORD_W-1:0]         cfg_data_i,
  input  logic [1:0]                 op_i,
  input  logic signed [COORD_W-1:0]  x_mm_i,
  input  logic signed [COORD_W-1:0]  y_mm_i,
  input  logic signed [COORD_W-1:0]  z_mm_i,
  input  logic [IDX_W-1:0]           read_row_i,
  input  logic [IDX_W-1:0]           read_col_i,
  output logic                       accepted_o,
  output logic [IDX_W-1:0]           cell_row_o,
  output logic [IDX_W-1:0]           cell_col_o,
  output logic [CNT_W-1:0]           point_count_o,
  output logic signed [COORD_W-1:0]  mean_height_mm_o,
  output logic                       obstacle_o,
  output logic signed [CORNER_W-1:0] cell_x_mm_o,
  output logic [CORNER_W-1:0]        cell_z_mm_o
);

  // configuration
  logic [SPAN_W-1:0]         x_span_q;
  logic [ZMAX_W-1:0]         z_max_q;
  logic signed [COORD_W-1:0] obs_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_span_q  <= X_SPAN_RST;
      z_max_q   <= Z_MAX_RST;
      obs_thr_q <= OBSTACLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_X_SPAN:   x_span_q  <= cfg_data_i[SPAN_W-1:0];
        REG_Z_MAX:    z_max_q   <= cfg_data_i[ZMAX_W-1:0];
        REG_OBSTACLE: obs_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]                op_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic [IDX_W-1:0]          rrow_q, rcol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= op_i;
      x_q    <= x_mm_i;
      y_q    <= y_mm_i;
      z_q    <= z_mm_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  // region check and binning
  logic signed [COORD_W:0] x_ext, z_ext, span_ext, zmax_ext, xo;
  logic                    in_region;
  logic [PROD_W-1:0]       col_prod, row_prod;
  logic                    inreg_q;
  logic [QBIN_W-1:0]       colq_q, rowq_q;

  always_comb begin
    x_ext     = {x_q[COORD_W-1], x_q};
    z_ext     = {z_q[COORD_W-1], z_q};
    span_ext  = {{(COORD_W+1-SPAN_W){1'b0}}, x_span_q};
    zmax_ext  = {{(COORD_W+1-ZMAX_W){1'b0}}, z_max_q};
    in_region = (x_ext > -span_ext) && (x_ext < span_ext) &&
                (z_ext > 17'sd0) && (z_ext < zmax_ext);
    // shift x so that the grid's left edge sits at zero
    xo        = x_ext + (COORD_W+1)'(HALF_MM);
    col_prod  = xo[BIN_IN_W-1:0] * BIN_RECIP;
    row_prod  = z_q[BIN_IN_W-1:0] * BIN_RECIP;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin) begin
      inreg_q <= in_region && !xo[COORD_W];
      colq_q  <= col_prod[PROD_W-1:BIN_SHIFT];
      rowq_q  <= row_prod[PROD_W-1:BIN_SHIFT];
    end
  end

  // cell select and memory read
  logic              hit_d, hit_q;
  logic [IDX_W-1:0]  row_d, col_d, row_q, col_q;
  logic [ADDR_W-1:0] addr_d, addr_q;

  always_comb begin
    if (op_q == OP_ADD) begin
      hit_d = inreg_q && (colq_q < QBIN_W'(GRID_SIZE)) && (rowq_q < QBIN_W'(GRID_SIZE));
      row_d = rowq_q[IDX_W-1:0];
      col_d = colq_q[IDX_W-1:0];
    end else begin
      hit_d = ({1'b0, rrow_q} < (IDX_W+1)'(GRID_SIZE)) &&
              ({1'b0, rcol_q} < (IDX_W+1)'(GRID_SIZE));
      row_d = rrow_q;
      col_d = rcol_q;
    end
    addr_d = ADDR_W'(row_d * GRID_SIZE) + ADDR_W'(col_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      hit_q  <= hit_d;
      row_q  <= row_d;
      col_q  <= col_d;
      addr_q <= addr_d;
    end
  end

  // clearing sweep address
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_last;

  assign clr_last = (clr_addr_q == ADDR_W'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // read-modify-write of the cell
  logic [WORD_W-1:0] rdata;
  logic [CNT_W-1:0]  rd_cnt, new_cnt, cnt_q;
  logic [SUM_W-1:0]  rd_sum, new_sum, sum_q;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  always_comb begin
    rd_cnt = rdata[WORD_W-1 -: CNT_W];
    rd_sum = rdata[SUM_W-1:0];
    new_cnt = rd_cnt;
    new_sum = rd_sum;
    // a saturated cell keeps its count and sum
    if (op_q == OP_ADD && rd_cnt != COUNT_MAX) begin
      new_cnt = rd_cnt + 1'b1;
      new_sum = rd_sum + {{(SUM_W-COORD_W){y_q[COORD_W-1]}}, y_q};
    end
    ram_we    = cmd_i.clr_step || (cmd_i.modify && hit_q && op_q == OP_ADD);
    ram_waddr = cmd_i.clr_step ? clr_addr_q : addr_q;
    ram_wdata = cmd_i.clr_step ? '0 : {new_cnt, new_sum};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      cnt_q <= new_cnt;
      sum_q <= new_sum;
    end
  end

  hgm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_d),
    .rdata_o (rdata)
  );

  // restoring divider on the magnitude of the sum, one quotient bit per cycle
  logic              neg_q;
  logic [SUM_W-1:0]  rem_q, dsh_q;
  logic [QUO_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W:0]    trial;

  assign trial = {1'b0, rem_q} - {1'b0, dsh_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.dset) begin
      neg_q  <= sum_q[SUM_W-1];
      rem_q  <= sum_q[SUM_W-1] ? -sum_q : sum_q;
      dsh_q  <= {cnt_q, {(QUO_W-1){1'b0}}};
      quo_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[SUM_W]) begin
        rem_q <= trial[SUM_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q + 1'b1;
    end
  end

  // result assembly
  logic                      r_nz, nonempty, res_ok, obs;
  logic [QUO_W:0]            mean_full;
  logic signed [COORD_W-1:0] mean16;
  logic [CORNER_W-1:0]       corner_x, corner_z;

  always_comb begin
    r_nz      = (rem_q != '0);
    // floor toward minus infinity for a negative sum
    mean_full = neg_q ? ((QUO_W+1)'(0) - {1'b0, quo_q} - {{QUO_W{1'b0}}, r_nz})
                      : {1'b0, quo_q};
    mean16    = mean_full[COORD_W-1:0];
    nonempty  = (cnt_q != '0);
    obs       = nonempty && (mean16 > obs_thr_q);
    res_ok    = hit_q && (op_q == OP_ADD || op_q == OP_READ);
    corner_x  = CORNER_W'(col_q * CELL_MM - HALF_MM);
    corner_z  = CORNER_W'(row_q * CELL_MM);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      accepted_o       <= res_ok && (op_q == OP_ADD);
      cell_row_o       <= res_ok ? row_q : '0;
      cell_col_o       <= res_ok ? col_q : '0;
      point_count_o    <= res_ok ? cnt_q : '0;
      mean_height_mm_o <= (res_ok && nonempty) ? mean16 : '0;
      obstacle_o       <= res_ok && obs;
      cell_x_mm_o      <= res_ok ? corner_x : '0;
      cell_z_mm_o      <= res_ok ? corner_z : '0;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.div_last = (step_q == STEP_W'(QUO_W - 1));
  assign sts_o.clr_last = clr_last;

endmodule

>>> design/hgm_ctrl.sv
module hgm_ctrl
  import hgm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_RCLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_BIN  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_DSET = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_OCLR = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_RCLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_BIN;
        end
      end
      S_BIN: begin
        cmd_o.bin = 1'b1;
        unique case (sts_i.op) inside
          OP_ADD, OP_READ: state_d = S_RD;
          OP_CLEAR:        state_d = S_OCLR;
          default:         state_d = S_DONE;
        endcase
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MOD;
      end
      S_MOD: begin
        cmd_o.modify = 1'b1;
        state_d      = S_DSET;
      end
      S_DSET: begin
        cmd_o.dset = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_OCLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        // wait only while the output register still holds an untaken item
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RCLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over an untaken item");

  a_accept_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_BIN))
    else $error("accepted item not binned next");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_DONE))
    else $error("divider finished without result");

  a_clr_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clr_step && sts_i.clr_last) |=> (state_q == S_IDLE || state_q == S_DONE))
    else $error("clear sweep ran past the last cell");
`endif

endmodule

>>> design/height_grid_map.sv
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o   | op, x/y/z point, read row/col
// out     | output    | out_valid_o / out_stall_i | accepted, cell, count, mean, flags
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// add point and read cell pass from accept to result through binning, the memory
// read, the cell update and the bit-serial mean divider; clear grid sweeps one cell
// per cycle through the single write port of the grid memory.
// after reset the same clearing pass runs before the first item.
// a finished result waits in the output register while the next item is taken;
// an item only stalls in its last cycle when the output register is still full.
module height_grid_map
  import hgm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic signed [COORD_W-1:0]  x_mm_i,
  input  logic signed [COORD_W-1:0]  y_mm_i,
  input  logic signed [COORD_W-1:0]  z_mm_i,
  input  logic [IDX_W-1:0]           read_row_i,
  input  logic [IDX_W-1:0]           read_col_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic [IDX_W-1:0]           cell_row_o,
  output logic [IDX_W-1:0]           cell_col_o,
  output logic [CNT_W-1:0]           point_count_o,
  output logic signed [COORD_W-1:0]  mean_height_mm_o,
  output logic                       obstacle_o,
  output logic signed [CORNER_W-1:0] cell_x_mm_o,
  output logic [CORNER_W-1:0]        cell_z_mm_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [COORD_W-1:0]         cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hgm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .x_mm_i           (x_mm_i),
    .y_mm_i           (y_mm_i),
    .z_mm_i           (z_mm_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .accepted_o       (accepted_o),
    .cell_row_o       (cell_row_o),
    .cell_col_o       (cell_col_o),
    .point_count_o    (point_count_o),
    .mean_height_mm_o (mean_height_mm_o),
    .obstacle_o       (obstacle_o),
    .cell_x_mm_o      (cell_x_mm_o),
    .cell_z_mm_o      (cell_z_mm_o)
  );

endmodule
